@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the sender modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define GBN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property that must hold in the cycle after a trigger
`define GBN_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

@@ hw/rtl/gbn_pkg.sv @@
// package for the go-back-n sender: constants, codes and beat types
package gbn_pkg;

  // sequence numbering and window limits
  localparam int SEQ_BITS   = 16;
  localparam int WINDOW_MAX = 16;
  localparam logic [15:0] SEQ_MASK =
    (SEQ_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << SEQ_BITS) - 64'd1);

  // configuration register reset values
  localparam logic [15:0] PACKET_COUNT_RST = 16'd0;
  localparam logic [4:0]  WINDOW_SIZE_RST  = 5'd1;
  localparam logic [15:0] TIMEOUT_RST      = 16'd1500;
  localparam logic        STRICT_RST       = 1'b0;

  // configuration register indexes
  localparam logic [1:0] REG_PACKET_COUNT = 2'd0;
  localparam logic [1:0] REG_WINDOW_SIZE  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT      = 2'd2;
  localparam logic [1:0] REG_STRICT       = 2'd3;

  // input event kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  // what the datapath emits for the current item
  localparam logic [1:0] MODE_STATUS = 2'd0;
  localparam logic [1:0] MODE_FILL   = 2'd1;
  localparam logic [1:0] MODE_RESEND = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] ack_seq;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [15:0] seq;
    logic        retransmit;
    logic [31:0] resent_total;
    logic        complete;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic eval;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic last_beat;
  } dp_status_t;

endpackage

@@ hw/rtl/gbn_ctrl.sv @@
// controller state machine: takes one item, then steps its result beats out
`include "assert_macros.svh"

module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EMIT = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;

  // handshake and commands
  always_comb begin
    in_ready   = (state == S_IDLE);
    cmd.eval   = 1'b0;
    cmd.emit   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.eval   = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_beat) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `GBN_ASSERT(a_emit_room, !cmd.emit || status.out_free, "beat loaded into a full output register")
  `GBN_ASSERT_NEXT(a_last_to_idle, cmd.emit && status.last_beat, state == S_IDLE, "no return to idle after last beat")
  `GBN_ASSERT(a_no_eval_in_emit, !(cmd.eval && cmd.emit), "item taken while beats still pending")

endmodule

@@ hw/rtl/gbn_datapath.sv @@
// datapath: configuration, window state, timer, resend total and output register
`include "assert_macros.svh"

module gbn_datapath
  import gbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  in_item_t    in_data,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  // configuration registers
  logic [15:0] packet_count;
  logic [4:0]  window_size;
  logic [15:0] timeout_ticks;
  logic        strict_ack_mode;

  // transfer state
  logic [15:0] base_seq, base_seq_next;
  logic [15:0] next_seq, next_seq_next;
  logic [15:0] timer_count, timer_count_next;
  logic [31:0] resend_count, resend_count_next;
  logic        transfer_active, transfer_active_next;
  logic [1:0]  mode, mode_next;
  logic [15:0] cursor, cursor_next;

  logic [15:0] win;
  logic [15:0] limit;
  logic [15:0] timer_inc;
  logic [15:0] in_flight;
  logic [32:0] resend_sum;
  logic        outstanding;
  logic        ack_match;
  logic        fill_now;
  logic        fill_more;
  logic [15:0] next_inc;
  logic [15:0] cursor_inc;
  out_item_t   beat;

  function automatic logic can_send(input logic act, input logic [15:0] nx,
                                    input logic [15:0] bs, input logic [15:0] pc,
                                    input logic [15:0] w);
    logic [15:0] diff;
    diff = nx - bs;
    return act && (nx < pc) && (diff < w);
  endfunction

  // effective window and timeout
  always_comb begin
    if (window_size == 5'd0) begin
      win = 16'd1;
    end else if ({11'b0, window_size} > 16'(WINDOW_MAX)) begin
      win = 16'(WINDOW_MAX);
    end else begin
      win = {11'b0, window_size};
    end
    limit = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
  end

  assign outstanding = transfer_active && (next_seq != base_seq);
  assign timer_inc   = timer_count + 16'd1;
  assign in_flight   = next_seq - base_seq;
  assign resend_sum  = {1'b0, resend_count} + {17'b0, in_flight};
  assign ack_match   = ((in_data.ack_seq & SEQ_MASK) == (base_seq & SEQ_MASK));
  assign next_inc    = next_seq + 16'd1;
  assign cursor_inc  = cursor + 16'd1;
  assign fill_more   = can_send(transfer_active, next_inc, base_seq, packet_count, win);

  // item evaluation and per-beat state update
  always_comb begin
    base_seq_next        = base_seq;
    next_seq_next        = next_seq;
    timer_count_next     = timer_count;
    resend_count_next    = resend_count;
    transfer_active_next = transfer_active;
    mode_next            = mode;
    cursor_next          = cursor;
    fill_now             = 1'b0;
    if (cmd.eval) begin
      mode_next = MODE_STATUS;
      case (in_data.kind)
        KIND_START: begin
          base_seq_next        = 16'd0;
          next_seq_next        = 16'd0;
          timer_count_next     = 16'd0;
          resend_count_next    = 32'd0;
          transfer_active_next = 1'b1;
          fill_now             = 1'b1;
        end
        KIND_TICK: begin
          if (outstanding) begin
            if (timer_inc >= limit) begin
              timer_count_next  = 16'd0;
              resend_count_next = resend_sum[32] ? 32'hFFFF_FFFF : resend_sum[31:0];
              cursor_next       = base_seq;
              mode_next         = MODE_RESEND;
            end else begin
              timer_count_next = timer_inc;
            end
          end else begin
            timer_count_next = 16'd0;
          end
        end
        KIND_ACK: begin
          if (outstanding) begin
            if (ack_match) begin
              base_seq_next    = base_seq + 16'd1;
              timer_count_next = 16'd0;
              fill_now         = 1'b1;
            end else if (strict_ack_mode) begin
              timer_count_next  = 16'd0;
              resend_count_next = resend_sum[32] ? 32'hFFFF_FFFF : resend_sum[31:0];
              cursor_next       = base_seq;
              mode_next         = MODE_RESEND;
            end
          end
        end
        default: begin
          if (!outstanding) begin
            timer_count_next = 16'd0;
          end
        end
      endcase
      // transfer ends once the oldest unacked number reaches the count
      if (transfer_active_next && (base_seq_next >= packet_count)) begin
        transfer_active_next = 1'b0;
      end
      if (!transfer_active_next || (next_seq_next == base_seq_next)) begin
        timer_count_next = 16'd0;
      end
      if (fill_now && can_send(transfer_active_next, next_seq_next, base_seq_next,
                               packet_count, win)) begin
        mode_next = MODE_FILL;
      end
    end else if (cmd.emit) begin
      if (mode == MODE_FILL) begin
        next_seq_next = next_inc;
      end else if (mode == MODE_RESEND) begin
        cursor_next = cursor_inc;
      end
    end
  end

  // beat under construction
  always_comb begin
    beat.resent_total = resend_count;
    beat.complete     = !transfer_active && (base_seq >= packet_count);
    case (mode)
      MODE_FILL: begin
        beat.send_valid = 1'b1;
        beat.seq        = next_seq & SEQ_MASK;
        beat.retransmit = 1'b0;
        beat.last       = !fill_more;
      end
      MODE_RESEND: begin
        beat.send_valid = 1'b1;
        beat.seq        = cursor & SEQ_MASK;
        beat.retransmit = 1'b1;
        beat.last       = (cursor_inc == next_seq);
      end
      default: begin
        beat.send_valid = 1'b0;
        beat.seq        = 16'd0;
        beat.retransmit = 1'b0;
        beat.last       = 1'b1;
      end
    endcase
  end

  assign status.out_free  = !out_valid || out_ready;
  assign status.last_beat = beat.last;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_count    <= PACKET_COUNT_RST;
      window_size     <= WINDOW_SIZE_RST;
      timeout_ticks   <= TIMEOUT_RST;
      strict_ack_mode <= STRICT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PACKET_COUNT: packet_count    <= cfg_data;
        REG_WINDOW_SIZE:  window_size     <= cfg_data[4:0];
        REG_TIMEOUT:      timeout_ticks   <= cfg_data;
        REG_STRICT:       strict_ack_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // transfer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq        <= 16'd0;
      next_seq        <= 16'd0;
      timer_count     <= 16'd0;
      resend_count    <= 32'd0;
      transfer_active <= 1'b0;
      mode            <= MODE_STATUS;
      cursor          <= 16'd0;
    end else begin
      base_seq        <= base_seq_next;
      next_seq        <= next_seq_next;
      timer_count     <= timer_count_next;
      resend_count    <= resend_count_next;
      transfer_active <= transfer_active_next;
      mode            <= mode_next;
      cursor          <= cursor_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= beat;
    end
  end

  `GBN_ASSERT(a_base_le_next, base_seq <= next_seq, "oldest unacked number passed next number")
  `GBN_ASSERT(a_resend_in_window, !(cmd.emit && mode == MODE_RESEND) || (cursor != next_seq), "resend beyond outstanding window")
  `GBN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "beat not held")

endmodule

@@ hw/rtl/go_back_n_arq_sender.sv @@
// top level of the go-back-n sender
//
// Three channels, each valid/ready. The cfg channel writes one register per
// beat (0 packet count, 1 window size, 2 timeout in ticks, 3 strict ack mode);
// it is always ready; the user must write it only while no item is in
// progress, as the block itself does not enforce it. The in channel carries
// events: start transfer, timer tick, ack received. Each event produces one
// or more beats on the out channel; the final beat of an event has last set.
// An event with no send gives a single status beat. A taken event updates
// the transfer state registers before its first beat is loaded. Beats per
// event run from 1 to the window limit; the output register loads one beat
// per cycle while the receiver does not stall, as fill and resend bursts
// step the sequence counter or resend cursor. The next event is taken while
// the final beat still waits in the output register. A stalled receiver
// holds the burst; nothing is dropped. Reset clears the transfer state and
// out_valid and restores the defaults (window 1, timeout 1500, packet count 0).
module go_back_n_arq_sender
  import gbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  // sequencing of event evaluation and beat emission
  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // window state and output register
  gbn_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
